// File: rtl/jpdt_pkg.sv
`default_nettype none

package jpdt_pkg;

    // joint set and field widths
    localparam int NUM_JOINTS  = 12;
    localparam int JOINT_W     = 4;
    localparam int POS_W       = 16;
    localparam int GAIN_W      = 12;
    localparam int BOUND_W     = 15;
    localparam int STEP_W      = 6;
    localparam int TORQUE_W    = 13;
    localparam int REG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // interpolation counter saturation
    localparam logic [STEP_W-1:0] STEP_MAX = 6'd63;

    // torque limit in whole Q4.8 units and its full-scale value
    localparam logic [3:0] LIMIT_MAX  = 4'd10;
    localparam int         TORQUE_MAX = 2560;

    // blend quotient: magnitude of (step+1)*(target-previous) fits 22 bits
    localparam int DIV_W     = 22;
    localparam int DIV_CNT_W = 5;

    // word queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef enum logic [1:0] {
        OP_INIT    = 2'd0,
        OP_LOAD    = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_KP_ABD    = 3'd0,
        REG_KP_HIP    = 3'd1,
        REG_KP_KNEE   = 3'd2,
        REG_KD_ABD    = 3'd3,
        REG_KD_HIP    = 3'd4,
        REG_KD_KNEE   = 3'd5,
        REG_MAX_ERROR = 3'd6,
        REG_REPEAT    = 3'd7
    } t_reg;

    typedef enum logic [1:0] {
        GRP_ABD,
        GRP_HIP,
        GRP_KNEE
    } t_group;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SCALE,
        ST_START,
        ST_DIV,
        ST_BLEND,
        ST_ERR,
        ST_MUL,
        ST_SUM
    } t_state;

    typedef struct packed {
        t_op                      op;
        logic [JOINT_W-1:0]       joint;
        logic signed [POS_W-1:0]  setpoint;
        logic signed [POS_W-1:0]  meas_pos;
        logic signed [POS_W-1:0]  meas_vel;
        logic signed [POS_W-1:0]  foot_force;
        logic                     eor;
    } t_cmd;

    typedef struct packed {
        logic [GAIN_W-1:0]  kp_abd;
        logic [GAIN_W-1:0]  kp_hip;
        logic [GAIN_W-1:0]  kp_knee;
        logic [GAIN_W-1:0]  kd_abd;
        logic [GAIN_W-1:0]  kd_hip;
        logic [GAIN_W-1:0]  kd_knee;
        logic [BOUND_W-1:0] max_error;
        logic [STEP_W-1:0]  repeat_count;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        kp_abd:       12'd800,
        kp_hip:       12'd800,
        kp_knee:      12'd800,
        kd_abd:       12'd16,
        kd_hip:       12'd32,
        kd_knee:      12'd32,
        max_error:    15'd717,
        repeat_count: 6'd10
    };

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [STEP_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_W-1:0]   quotient;
        logic [STEP_W-1:0]  remainder;
    } t_div_rsp;

    // joint index modulo three picks the gain set
    function automatic t_group joint_group(input logic [JOINT_W-1:0] joint);
        t_group grp;
        case (joint)
            4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: grp = GRP_ABD;
            4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       grp = GRP_HIP;
            default:                              grp = GRP_KNEE;
        endcase
        return grp;
    endfunction

endpackage

`default_nettype wire

// File: rtl/jpdt_if.sv
`default_nettype none

interface jpdt_in_if;
    import jpdt_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [1:0]               op;
    logic [JOINT_W-1:0]       joint;
    logic signed [POS_W-1:0]  setpoint;
    logic signed [POS_W-1:0]  measured_position;
    logic signed [POS_W-1:0]  measured_velocity;
    logic signed [POS_W-1:0]  foot_force;
    logic                     end_of_round;

    modport source (
        output valid, op, joint, setpoint, measured_position, measured_velocity,
               foot_force, end_of_round,
        input  ready
    );
    modport sink (
        input  valid, op, joint, setpoint, measured_position, measured_velocity,
               foot_force, end_of_round,
        output ready
    );
endinterface

interface jpdt_out_if;
    import jpdt_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [JOINT_W-1:0]         joint_out;
    logic signed [TORQUE_W-1:0] torque;

    modport source (output valid, joint_out, torque, input ready);
    modport sink (input valid, joint_out, torque, output ready);
endinterface

interface jpdt_cfg_if;
    import jpdt_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [REG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/joint_pd_torque_with_interpolation_core.sv
// A compute word gives a torque result; init and load words give no result.
// The back end works on one word at a time, and a compute word is paced by the
// 22-step restoring divider that forms the interpolation fraction.
// A 4-word queue keeps accepting while the back end works or a result waits.
// Reset (synchronous, active low) clears setpoints and the counter, loads default gains.
`default_nettype none

module joint_pd_torque_with_interpolation_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    jpdt_in_if.sink    i_in,
    jpdt_cfg_if.sink   i_cfg,
    jpdt_out_if.source o_out
);
    import jpdt_pkg::*;

    t_cfg r_cfg;
    logic w_push;
    t_cmd w_push_cmd;
    logic w_pop;
    logic w_q_valid;
    logic w_q_full;
    t_cmd w_q_cmd;

    // configuration registers, always ready
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_reg'(i_cfg.index))
                REG_KP_ABD:    r_cfg.kp_abd       <= i_cfg.data[GAIN_W-1:0];
                REG_KP_HIP:    r_cfg.kp_hip       <= i_cfg.data[GAIN_W-1:0];
                REG_KP_KNEE:   r_cfg.kp_knee      <= i_cfg.data[GAIN_W-1:0];
                REG_KD_ABD:    r_cfg.kd_abd       <= i_cfg.data[GAIN_W-1:0];
                REG_KD_HIP:    r_cfg.kd_hip       <= i_cfg.data[GAIN_W-1:0];
                REG_KD_KNEE:   r_cfg.kd_knee      <= i_cfg.data[GAIN_W-1:0];
                REG_MAX_ERROR: r_cfg.max_error    <= i_cfg.data[BOUND_W-1:0];
                REG_REPEAT:    r_cfg.repeat_count <= i_cfg.data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    jpdt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_q_full),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    jpdt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_cmd   (w_q_cmd)
    );

    jpdt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .i_q_cmd   (w_q_cmd),
        .o_q_pop   (w_pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

// File: rtl/jpdt_div.sv
`default_nettype none

module jpdt_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire jpdt_pkg::t_div_req i_req,
    output jpdt_pkg::t_div_rsp      o_rsp
);
    import jpdt_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_quo;
    logic [STEP_W-1:0]    r_rem;
    logic [STEP_W-1:0]    r_div;

    logic [STEP_W:0]      w_rem_sh;
    logic                 w_bit;
    logic [STEP_W-1:0]    w_rem_n;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        w_rem_sh = {r_rem, r_quo[DIV_W-1]};
        w_bit    = (w_rem_sh >= {1'b0, r_div});
        w_rem_n  = w_bit ? STEP_W'(w_rem_sh - {1'b0, r_div}) : STEP_W'(w_rem_sh);
    end

    // control: busy for one step per quotient bit, done pulses once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // datapath: quotient bits shift in where the dividend shifts out
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], w_bit};
            r_rem <= w_rem_n;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

`default_nettype wire

// File: rtl/jpdt_front.sv
`default_nettype none

module jpdt_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    jpdt_in_if.sink             i_in,
    input  wire logic           i_full,
    output logic                o_push,
    output jpdt_pkg::t_cmd      o_cmd
);
    import jpdt_pkg::*;

    logic r_valid;
    logic r_keep;
    t_cmd r_cmd;
    logic w_drain;
    logic w_accept;
    logic w_keep;

    // a held word leaves when dropped or when the queue has room
    assign w_drain  = r_valid && (!r_keep || !i_full);
    assign i_in.ready = !r_valid || w_drain;
    assign w_accept = i_in.valid && i_in.ready;

    // drop unused op codes and joints beyond the set
    assign w_keep = (t_op'(i_in.op) != OP_NONE) &&
                    (i_in.joint < JOINT_W'(NUM_JOINTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (w_drain) begin
            r_valid <= 1'b0;
        end
    end

    // capture the classified word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_keep           <= w_keep;
            r_cmd.op         <= t_op'(i_in.op);
            r_cmd.joint      <= i_in.joint;
            r_cmd.setpoint   <= i_in.setpoint;
            r_cmd.meas_pos   <= i_in.measured_position;
            r_cmd.meas_vel   <= i_in.measured_velocity;
            r_cmd.foot_force <= i_in.foot_force;
            r_cmd.eor        <= i_in.end_of_round;
        end
    end

    assign o_push = r_valid && r_keep && !i_full;
    assign o_cmd  = r_cmd;

endmodule

`default_nettype wire

// File: rtl/jpdt_queue.sv
`default_nettype none

module jpdt_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire jpdt_pkg::t_cmd i_cmd,
    input  wire logic           i_pop,
    output logic                o_valid,
    output logic                o_full,
    output jpdt_pkg::t_cmd      o_cmd
);
    import jpdt_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    // advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // store the incoming word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_cmd   = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

// File: rtl/jpdt_back.sv
`default_nettype none

module jpdt_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire jpdt_pkg::t_cfg i_cfg,
    input  wire logic           i_q_valid,
    input  wire jpdt_pkg::t_cmd i_q_cmd,
    output logic                o_q_pop,
    jpdt_out_if.source          o_out
);
    import jpdt_pkg::*;

    t_state r_state;
    t_state n_state;

    // per-joint setpoints and the shared interpolation counter
    logic signed [POS_W-1:0] r_prev_pos [NUM_JOINTS];
    logic signed [POS_W-1:0] r_tgt_pos  [NUM_JOINTS];
    logic [STEP_W-1:0]       r_step;

    // working registers of one compute word
    t_cmd                    r_cmd;
    logic signed [POS_W-1:0] r_prev;
    logic signed [POS_W:0]   r_diff;
    logic [GAIN_W-1:0]       r_kp;
    logic [GAIN_W-1:0]       r_kd;
    logic [3:0]              r_lim;
    logic                    r_neg;
    logic [DIV_W-1:0]        r_mag;
    logic [DIV_W-1:0]        r_qr;
    logic signed [23:0]      r_blend;
    logic signed [POS_W-1:0] r_err;
    logic signed [28:0]      r_pterm;
    logic signed [28:0]      r_dterm;

    // output register
    logic                       r_out_valid;
    logic [JOINT_W-1:0]         r_out_joint;
    logic signed [TORQUE_W-1:0] r_out_torque;

    logic w_out_load;
    logic w_div_start;

    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    logic [GAIN_W-1:0]       w_kp;
    logic [GAIN_W-1:0]       w_kd;
    logic [3:0]              w_lim;
    logic [12:0]             w_force_q;
    logic signed [24:0]      w_prod;
    logic signed [24:0]      w_prod_abs;
    logic [STEP_W-1:0]       w_divisor;
    logic                    w_rnd;
    logic signed [23:0]      w_qr_s;
    logic signed [24:0]      w_err_full;
    logic signed [24:0]      w_bound;
    logic signed [24:0]      w_err_clip;
    logic signed [33:0]      w_t16;
    logic signed [33:0]      w_tq;
    logic signed [33:0]      w_lim_q;
    logic signed [33:0]      w_tq_clip;

    // ---------------- sequencer ----------------

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_q_valid) n_state = ST_FETCH;
            ST_FETCH: n_state = (r_cmd.op == OP_COMPUTE) ? ST_SCALE : ST_IDLE;
            ST_SCALE: n_state = ST_START;
            ST_START: n_state = ST_DIV;
            ST_DIV:   if (w_div_rsp.done) n_state = ST_BLEND;
            ST_BLEND: n_state = ST_ERR;
            ST_ERR:   n_state = ST_MUL;
            ST_MUL:   n_state = ST_SUM;
            ST_SUM:   if (w_out_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop     = 1'b0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        case (r_state)
            ST_IDLE:  o_q_pop     = i_q_valid;
            ST_START: w_div_start = 1'b1;
            ST_SUM:   w_out_load  = !r_out_valid || o_out.ready;
            default:  ;
        endcase
    end

    // ---------------- arithmetic ----------------

    always_comb begin
        // gain set of this joint
        case (joint_group(r_cmd.joint))
            GRP_ABD: begin
                w_kp = i_cfg.kp_abd;
                w_kd = i_cfg.kd_abd;
            end
            GRP_HIP: begin
                w_kp = i_cfg.kp_hip;
                w_kd = i_cfg.kd_hip;
            end
            default: begin
                w_kp = i_cfg.kp_knee;
                w_kd = i_cfg.kd_knee;
            end
        endcase

        // leg limit in whole units: 1 + force/4 for positive force, capped
        w_force_q = r_cmd.foot_force[14:2];
        if (r_cmd.foot_force <= 0) begin
            w_lim = 4'd1;
        end else if (w_force_q >= 13'(LIMIT_MAX - 4'd1)) begin
            w_lim = LIMIT_MAX;
        end else begin
            w_lim = w_force_q[3:0] + 4'd1;
        end

        // scale the setpoint step by the counter
        w_prod     = $signed({1'b0, {1'b0, r_step} + 7'd1}) * r_diff;
        w_prod_abs = w_prod[24] ? -w_prod : w_prod;

        // round the quotient to nearest, ties away from zero
        w_divisor = (i_cfg.repeat_count == '0) ? STEP_W'(1) : i_cfg.repeat_count;
        w_rnd     = ({w_div_rsp.remainder, 1'b0} >= {1'b0, w_divisor});

        // signed blend offset
        w_qr_s = r_neg ? -$signed({2'b0, r_qr}) : $signed({2'b0, r_qr});

        // position error, clipped to the bound
        w_err_full = 25'(r_cmd.meas_pos) - 25'(r_blend);
        w_bound    = $signed({10'b0, i_cfg.max_error});
        if (w_err_full > w_bound) begin
            w_err_clip = w_bound;
        end else if (w_err_full < -w_bound) begin
            w_err_clip = -w_bound;
        end else begin
            w_err_clip = w_err_full;
        end

        // torque with 16 fraction bits, round to Q4.8, clamp to the leg limit
        w_t16   = -34'(r_pterm) - (34'(r_dterm) <<< 4);
        w_tq    = (w_t16 + 34'sd128) >>> 8;
        w_lim_q = $signed({22'b0, r_lim, 8'b0});
        if (w_tq > w_lim_q) begin
            w_tq_clip = w_lim_q;
        end else if (w_tq < -w_lim_q) begin
            w_tq_clip = -w_lim_q;
        end else begin
            w_tq_clip = w_tq;
        end
    end

    // ---------------- divider ----------------

    assign w_div_req.start    = w_div_start;
    assign w_div_req.dividend = r_mag;
    assign w_div_req.divisor  = w_divisor;

    jpdt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // ---------------- control state ----------------

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            for (int i = 0; i < NUM_JOINTS; i++) begin
                r_prev_pos[i] <= '0;
                r_tgt_pos[i]  <= '0;
            end
        end else begin
            r_state <= n_state;

            // setpoint writes
            if (r_state == ST_FETCH) begin
                case (r_cmd.op)
                    OP_INIT: begin
                        r_prev_pos[r_cmd.joint] <= r_cmd.setpoint;
                        r_tgt_pos[r_cmd.joint]  <= r_cmd.setpoint;
                    end
                    OP_LOAD: begin
                        r_prev_pos[r_cmd.joint] <= r_tgt_pos[r_cmd.joint];
                        r_tgt_pos[r_cmd.joint]  <= r_cmd.setpoint;
                        if (r_cmd.eor) begin
                            r_step <= '0;
                        end
                    end
                    default: ;
                endcase
            end

            // advance the counter after the last compute of a round
            if (w_out_load && r_cmd.eor && (r_step != STEP_MAX)) begin
                r_step <= r_step + 1'b1;
            end

            // hold the result until taken
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- working registers ----------------

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_cmd <= i_q_cmd;
            end
            ST_FETCH: begin
                r_prev <= r_prev_pos[r_cmd.joint];
                r_diff <= (POS_W+1)'(r_tgt_pos[r_cmd.joint]) -
                          (POS_W+1)'(r_prev_pos[r_cmd.joint]);
                r_kp   <= w_kp;
                r_kd   <= w_kd;
                r_lim  <= w_lim;
            end
            ST_SCALE: begin
                r_neg <= w_prod[24];
                r_mag <= w_prod_abs[DIV_W-1:0];
            end
            ST_DIV: begin
                if (w_div_rsp.done) begin
                    r_qr <= w_div_rsp.quotient + {{(DIV_W-1){1'b0}}, w_rnd};
                end
            end
            ST_BLEND: begin
                r_blend <= 24'(r_prev) + w_qr_s;
            end
            ST_ERR: begin
                r_err <= w_err_clip[POS_W-1:0];
            end
            ST_MUL: begin
                r_pterm <= $signed({1'b0, r_kp}) * r_err;
                r_dterm <= $signed({1'b0, r_kd}) * r_cmd.meas_vel;
            end
            ST_SUM: begin
                if (w_out_load) begin
                    r_out_joint  <= r_cmd.joint;
                    r_out_torque <= w_tq_clip[TORQUE_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.joint_out = r_out_joint;
    assign o_out.torque    = r_out_torque;

endmodule

`default_nettype wire

// File: rtl/jpdt_checker.sv
`default_nettype none

module jpdt_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_out_valid,
    input wire logic                               i_out_ready,
    input wire logic [jpdt_pkg::JOINT_W-1:0]       i_joint_out,
    input wire logic signed [jpdt_pkg::TORQUE_W-1:0] i_torque
);
    import jpdt_pkg::*;

    // torque never leaves the largest leg limit
    a_torque_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_torque >= -TORQUE_W'(TORQUE_MAX)) &&
                        (i_torque <= TORQUE_W'(TORQUE_MAX)))
        else $error("torque beyond leg limit");

    // only joints of the set produce results
    a_joint_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_joint_out < JOINT_W'(NUM_JOINTS)))
        else $error("result for joint outside the set");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_torque) && $stable(i_joint_out))
        else $error("stalled result changed");

    // reset drops any pending result
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind joint_pd_torque_with_interpolation_core jpdt_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_joint_out (o_out.joint_out),
    .i_torque    (o_out.torque)
);

`default_nettype wire
